// ----- src/jpeg_frame_marker_locator_assert.svh -----
// ----------------------------------------------------------------------------
// JPEG frame marker locator: assertion macros
// Shared concurrent assertion forms used by the locator RTL.
// ----------------------------------------------------------------------------
`ifndef JPEG_FRAME_MARKER_LOCATOR_ASSERT_SVH
`define JPEG_FRAME_MARKER_LOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define JFML_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define JFML_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/jfml_pkg.sv -----
// ----------------------------------------------------------------------------
// jfml_pkg
// Types and constants shared by the JPEG frame marker locator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package jfml_pkg;

    // Width of byte positions, offsets and lengths
    localparam int POS_BITS = 20;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [7:0] MARK_LEAD = 8'hFF;
    localparam logic [7:0] MARK_SOI  = 8'hD8;
    localparam logic [7:0] MARK_EOI  = 8'hD9;

    localparam logic [POS_BITS-1:0] HEAD_LIMIT_RESET = POS_BITS'(10000);
    localparam logic [POS_BITS-1:0] TAIL_LIMIT_RESET = POS_BITS'(1048573);

    typedef logic [POS_BITS-1:0] pos_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_HEAD_LIMIT = 1'b0,
        REG_TAIL_LIMIT = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_FOUND        = 2'd0,
        ST_NO_START     = 2'd1,
        ST_NO_END       = 2'd2,
        ST_SECOND_START = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_HEAD = 2'd0,
        PH_TAIL = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    // One input beat
    typedef struct packed {
        logic [7:0] data_byte;
        pos_t       tail_start;
        logic       last_byte;
    } in_beat_t;

    // One result beat
    typedef struct packed {
        status_t status;
        pos_t    head_offset;
        pos_t    image_length;
    } result_t;

    // Decision handed from the scanner to the result stage
    typedef struct packed {
        logic    emit;
        result_t result;
    } decision_t;

endpackage

`default_nettype wire

// ----- src/jfml_in_stage.sv -----
// ----------------------------------------------------------------------------
// jfml_in_stage
// Input register: captures one byte beat and holds it until the scanner
// consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module jfml_in_stage (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire jfml_pkg::in_beat_t s_beat,
    input  wire logic               consume,
    output logic                    beat_valid,
    output jfml_pkg::in_beat_t      beat
);

    logic               valid_reg;
    logic               valid_next;
    jfml_pkg::in_beat_t beat_reg;

    // Take a new beat when empty or when the held one leaves this cycle
    assign s_ready    = !valid_reg || consume;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !consume);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on accept
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            beat_reg <= s_beat;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

`default_nettype wire

// ----- src/jfml_scan.sv -----
// ----------------------------------------------------------------------------
// jfml_scan
// Frame state and marker decision: tracks position and search phase, and
// decides the result for each consumed byte in a single pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "jpeg_frame_marker_locator_assert.svh"

module jfml_scan (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               fire,
    input  wire jfml_pkg::in_beat_t beat,
    input  wire jfml_pkg::pos_t     head_limit,
    input  wire jfml_pkg::pos_t     tail_limit,
    output jfml_pkg::decision_t     dec
);

    localparam int PB = jfml_pkg::POS_BITS;

    logic [7:0]       prev_reg,   prev_next;
    jfml_pkg::pos_t   pos_reg,    pos_next;
    jfml_pkg::phase_t phase_reg,  phase_next;
    jfml_pkg::pos_t   start_reg,  start_next;
    jfml_pkg::pos_t   origin_reg, origin_next;

    jfml_pkg::pos_t   origin;
    jfml_pkg::pos_t   pos_m1;
    jfml_pkg::pos_t   rel;
    jfml_pkg::pos_t   first_cand;
    logic [PB:0]      rel_p1;
    logic [PB:0]      next_cand;
    logic [PB:0]      len_raw;
    jfml_pkg::pos_t   len_sat;
    logic             head_hit;
    logic             head_over;
    logic             enter_empty;
    logic             tail_pair;
    logic             tail_soi;
    logic             tail_eoi;
    logic             tail_over;
    jfml_pkg::phase_t phase_after;
    jfml_pkg::pos_t   start_after;

    // Shared compare terms
    always_comb begin
        origin      = (pos_reg == '0) ? beat.tail_start : origin_reg;
        pos_m1      = pos_reg - PB'(1);
        head_hit    = (pos_reg != '0) && (pos_m1 < head_limit) &&
                      (prev_reg == jfml_pkg::MARK_LEAD) &&
                      (beat.data_byte == jfml_pkg::MARK_SOI);
        head_over   = (pos_reg >= head_limit);
        first_cand  = (origin == '0) ? PB'(1) : origin;
        enter_empty = (first_cand >= tail_limit);
        rel         = pos_m1 - start_reg;
        tail_pair   = (rel < tail_limit) && (rel >= origin) &&
                      (prev_reg == jfml_pkg::MARK_LEAD);
        tail_soi    = tail_pair && (beat.data_byte == jfml_pkg::MARK_SOI) &&
                      (rel != '0);
        tail_eoi    = tail_pair && (beat.data_byte == jfml_pkg::MARK_EOI);
        rel_p1      = {1'b0, rel} + (PB+1)'(1);
        next_cand   = (rel_p1 > {1'b0, origin}) ? rel_p1 : {1'b0, origin};
        tail_over   = (next_cand >= {1'b0, tail_limit});
        len_raw     = {1'b0, rel} + (PB+1)'(2);
        len_sat     = len_raw[PB] ? '1 : len_raw[PB-1:0];
    end

    // Decision for the current byte
    always_comb begin
        dec                     = '0;
        dec.result.status       = jfml_pkg::ST_FOUND;
        phase_after             = phase_reg;
        start_after             = start_reg;
        unique case (phase_reg)
            jfml_pkg::PH_HEAD: begin
                if (head_hit) begin
                    phase_after = jfml_pkg::PH_TAIL;
                    start_after = pos_m1;
                    if (enter_empty) begin
                        dec.emit               = 1'b1;
                        dec.result.status      = jfml_pkg::ST_NO_END;
                        dec.result.head_offset = pos_m1;
                    end
                end else if (head_over) begin
                    dec.emit          = 1'b1;
                    dec.result.status = jfml_pkg::ST_NO_START;
                end
            end
            jfml_pkg::PH_TAIL: begin
                dec.result.head_offset = start_reg;
                if (tail_soi) begin
                    dec.emit          = 1'b1;
                    dec.result.status = jfml_pkg::ST_SECOND_START;
                end else if (tail_eoi) begin
                    dec.emit                = 1'b1;
                    dec.result.status       = jfml_pkg::ST_FOUND;
                    dec.result.image_length = len_sat;
                end else if (tail_over) begin
                    dec.emit          = 1'b1;
                    dec.result.status = jfml_pkg::ST_NO_END;
                end
            end
            default: begin
            end
        endcase
        if (dec.emit) begin
            phase_after = jfml_pkg::PH_DONE;
        end
        // Close out an undecided frame on its last byte
        if (beat.last_byte && !dec.emit) begin
            if (phase_after == jfml_pkg::PH_HEAD) begin
                dec.emit          = 1'b1;
                dec.result        = '0;
                dec.result.status = jfml_pkg::ST_NO_START;
            end else if (phase_after == jfml_pkg::PH_TAIL) begin
                dec.emit                = 1'b1;
                dec.result.status       = jfml_pkg::ST_NO_END;
                dec.result.head_offset  = start_after;
                dec.result.image_length = '0;
            end
        end
        dec.emit = dec.emit && fire;
    end

    // Next frame state
    always_comb begin
        prev_next   = prev_reg;
        pos_next    = pos_reg;
        phase_next  = phase_reg;
        start_next  = start_reg;
        origin_next = origin_reg;
        if (fire) begin
            if (beat.last_byte) begin
                prev_next   = '0;
                pos_next    = '0;
                phase_next  = jfml_pkg::PH_HEAD;
                start_next  = '0;
                origin_next = '0;
            end else begin
                prev_next   = beat.data_byte;
                pos_next    = (pos_reg == '1) ? pos_reg : pos_reg + PB'(1);
                phase_next  = phase_after;
                start_next  = start_after;
                origin_next = origin;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg   <= '0;
            pos_reg    <= '0;
            phase_reg  <= jfml_pkg::PH_HEAD;
            start_reg  <= '0;
            origin_reg <= '0;
        end else begin
            prev_reg   <= prev_next;
            pos_reg    <= pos_next;
            phase_reg  <= phase_next;
            start_reg  <= start_next;
            origin_reg <= origin_next;
        end
    end

    `JFML_ASSERT_NOW(a_no_start_zero_head, aclk, aresetn,
        dec.emit && (dec.result.status == jfml_pkg::ST_NO_START),
        dec.result.head_offset == '0, "no-start result carries a head offset")
    `JFML_ASSERT_NOW(a_len_only_found, aclk, aresetn,
        dec.emit && (dec.result.status != jfml_pkg::ST_FOUND),
        dec.result.image_length == '0, "length set on a failed frame")
    `JFML_ASSERT_NOW(a_decided_silent, aclk, aresetn,
        (phase_reg != jfml_pkg::PH_HEAD) && (phase_reg != jfml_pkg::PH_TAIL),
        !dec.emit, "second result for a decided frame")
    `JFML_ASSERT_NEXT(a_last_clears, aclk, aresetn,
        fire && beat.last_byte,
        (pos_reg == '0) && (phase_reg == jfml_pkg::PH_HEAD),
        "frame state not cleared after last byte")

endmodule

`default_nettype wire

// ----- src/jfml_out_stage.sv -----
// ----------------------------------------------------------------------------
// jfml_out_stage
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module jfml_out_stage (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire jfml_pkg::decision_t dec,
    output logic                     can_load,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output jfml_pkg::result_t        m_result
);

    logic              valid_reg;
    logic              valid_next;
    jfml_pkg::result_t result_reg;

    // Room when empty or when the held result leaves this cycle
    assign can_load   = !valid_reg || m_ready;
    assign valid_next = dec.emit || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture a new result
    always_ff @(posedge aclk) begin
        if (dec.emit) begin
            result_reg <= dec.result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

`default_nettype wire

// ----- src/jpeg_frame_marker_locator.sv -----
// ----------------------------------------------------------------------------
// jpeg_frame_marker_locator
// Finds the FF D8 / FF D9 markers of one JPEG image in a camera frame buffer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one buffer byte per beat, with s_tail_start sampled on
//   the first byte of a frame and s_last_byte on the final byte.
//   Result channel m_*: at most one beat per frame carrying status, the start
//   marker offset and the image length (end offset plus 2).
//   Configuration: cfg_wr_en writes cfg_wr_data to the register selected by
//   cfg_wr_addr (0 head search limit, 1 tail search limit); write only while
//   the block is idle.
//   Path: the byte that decides a result is accepted into the input
//   register; once consumed, its decision lands in the result register,
//   which drives m_valid.
//   Throughput: one byte per cycle while the result register has room; the
//   decision is a handful of 20-bit compares between the two registers.
//   Reset: clears the frame state and the valid flags of both pipeline
//   registers; the limits return to 10000 and 1048573.
//   Stall: while m_ready is low a held result blocks the next decision;
//   then, once the input register holds a byte, s_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module jpeg_frame_marker_locator (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [jfml_pkg::CFG_INDEX_BITS-1:0]   cfg_wr_addr,
    input  wire logic [jfml_pkg::POS_BITS-1:0]         cfg_wr_data,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [7:0]                            s_data_byte,
    input  wire logic [jfml_pkg::POS_BITS-1:0]         s_tail_start,
    input  wire logic                                  s_last_byte,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [1:0]                                 m_status,
    output logic [jfml_pkg::POS_BITS-1:0]              m_head_offset,
    output logic [jfml_pkg::POS_BITS-1:0]              m_image_length
);

    jfml_pkg::pos_t      head_limit_reg;
    jfml_pkg::pos_t      tail_limit_reg;
    jfml_pkg::in_beat_t  s_beat;
    jfml_pkg::in_beat_t  beat;
    logic                beat_valid;
    logic                can_load;
    logic                fire;
    jfml_pkg::decision_t dec;
    jfml_pkg::result_t   m_result;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_limit_reg <= jfml_pkg::HEAD_LIMIT_RESET;
            tail_limit_reg <= jfml_pkg::TAIL_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            unique case (jfml_pkg::cfg_index_t'(cfg_wr_addr))
                jfml_pkg::REG_HEAD_LIMIT: head_limit_reg <= cfg_wr_data;
                jfml_pkg::REG_TAIL_LIMIT: tail_limit_reg <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    assign s_beat.data_byte  = s_data_byte;
    assign s_beat.tail_start = s_tail_start;
    assign s_beat.last_byte  = s_last_byte;

    // Advance a held byte whenever the result register has room
    assign fire = beat_valid && can_load;

    jfml_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_beat     (s_beat),
        .consume    (fire),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    jfml_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .beat       (beat),
        .head_limit (head_limit_reg),
        .tail_limit (tail_limit_reg),
        .dec        (dec)
    );

    jfml_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .dec      (dec),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_status       = m_result.status;
    assign m_head_offset  = m_result.head_offset;
    assign m_image_length = m_result.image_length;

endmodule

`default_nettype wire

// ----- bench/tb_jpeg_frame_marker_locator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_jpeg_frame_marker_locator
// Self-checking bench for the JPEG start/end marker locator. Frame buffers
// are streamed in byte by byte, and each beat is run through a local model of
// the marker search as it is accepted. Every report is checked field by field
// against the oldest prediction. The limits are set in turn to several pairs,
// from 1 up to 20'hFFFFF, and both channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb_jpeg_frame_marker_locator;

    localparam int     PHASES        = 8;
    localparam int     PHASE_BYTES   = 165;
    localparam int     SETTLE_CYCLES = 4;
    localparam int     LONG_HOLD     = 400;
    localparam int     QUIET_LIMIT   = 3000;
    localparam int     REPORT_LIMIT  = 10;
    localparam longint LEN_CAP       = (64'd1 << jfml_pkg::POS_BITS) - 1;

    // Ports of the block
    logic                                aclk        = 1'b0;
    logic                                aresetn     = 1'b0;
    logic                                cfg_wr_en   = 1'b0;
    logic [jfml_pkg::CFG_INDEX_BITS-1:0] cfg_wr_addr = '0;
    jfml_pkg::pos_t                      cfg_wr_data = '0;
    logic                                s_valid     = 1'b0;
    logic                                s_ready;
    logic [7:0]                          s_data_byte = '0;
    jfml_pkg::pos_t                      s_tail_start = '0;
    logic                                s_last_byte = 1'b0;
    logic                                m_valid;
    logic                                m_ready     = 1'b0;
    logic [1:0]                          m_status;
    jfml_pkg::pos_t                      m_head_offset;
    jfml_pkg::pos_t                      m_image_length;

    // Bytes waiting to be sent and reports waiting to arrive
    jfml_pkg::in_beat_t byte_stream[$];
    jfml_pkg::result_t  awaited_reports[$];

    // Local copy of the limits and of the per-frame search state
    jfml_pkg::pos_t    head_lim   = jfml_pkg::HEAD_LIMIT_RESET;
    jfml_pkg::pos_t    tail_lim   = jfml_pkg::TAIL_LIMIT_RESET;
    logic [7:0]        prev_byte  = '0;
    jfml_pkg::pos_t    scan_pos   = '0;
    jfml_pkg::phase_t  scan_phase = jfml_pkg::PH_HEAD;
    jfml_pkg::pos_t    start_off  = '0;
    jfml_pkg::pos_t    tail_org   = '0;
    bit                decided;
    jfml_pkg::result_t verdict;

    // Run bookkeeping
    int fault_count   = 0;
    int bytes_sent    = 0;
    int reports_seen  = 0;
    int frames_queued = 0;
    int phase_bytes   = 0;
    int status_seen [4] = '{default: 0};
    int tx_gap        = 0;
    int rx_wait       = 0;
    int rx_hold_len   = 0;
    int quiet_cycles  = 0;
    bit tx_calm       = 1'b0;
    bit rx_calm       = 1'b0;

    jpeg_frame_marker_locator uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_addr    (cfg_wr_addr),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_tail_start   (s_tail_start),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_head_offset  (m_head_offset),
        .m_image_length (m_image_length)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Close the frame's search with one report
    function automatic void settle(jfml_pkg::status_t st, jfml_pkg::pos_t head,
                                   longint len);
        verdict.status       = st;
        verdict.head_offset  = head;
        verdict.image_length = jfml_pkg::pos_t'((len > LEN_CAP) ? LEN_CAP : len);
        decided              = 1'b1;
        scan_phase           = jfml_pkg::PH_DONE;
    endfunction

    // True when no end-marker position is left after relative offset rel
    function automatic bit tail_used_up(longint rel);
        longint next_rel;
        next_rel = rel + 1;
        if (longint'(tail_org) > next_rel)
            next_rel = longint'(tail_org);
        return next_rel >= longint'(tail_lim);
    endfunction

    // Advance the marker search by one byte; sets decided and verdict
    function automatic void locate_markers(jfml_pkg::in_beat_t b);
        longint rel;
        decided = 1'b0;
        verdict = '0;
        if (scan_pos == '0)
            tail_org = b.tail_start;
        case (scan_phase)
            jfml_pkg::PH_HEAD: begin
                if (scan_pos >= 1 && scan_pos - 1 < head_lim &&
                    prev_byte == jfml_pkg::MARK_LEAD &&
                    b.data_byte == jfml_pkg::MARK_SOI) begin
                    start_off  = scan_pos - 1'b1;
                    scan_phase = jfml_pkg::PH_TAIL;
                    if (tail_used_up(0))
                        settle(jfml_pkg::ST_NO_END, start_off, 0);
                end else if (scan_pos >= head_lim) begin
                    settle(jfml_pkg::ST_NO_START, '0, 0);
                end
            end
            jfml_pkg::PH_TAIL: begin
                rel = longint'(scan_pos) - longint'(start_off) - 1;
                if (rel < longint'(tail_lim) && rel >= longint'(tail_org) &&
                    prev_byte == jfml_pkg::MARK_LEAD) begin
                    // the opening marker itself sits at offset zero
                    if (b.data_byte == jfml_pkg::MARK_SOI && rel != 0)
                        settle(jfml_pkg::ST_SECOND_START, start_off, 0);
                    else if (b.data_byte == jfml_pkg::MARK_EOI)
                        settle(jfml_pkg::ST_FOUND, start_off, rel + 2);
                end
                if (!decided && tail_used_up(rel))
                    settle(jfml_pkg::ST_NO_END, start_off, 0);
            end
            default: ;
        endcase
        if (b.last_byte) begin
            // frame ended before a decision
            if (!decided && scan_phase == jfml_pkg::PH_HEAD)
                settle(jfml_pkg::ST_NO_START, '0, 0);
            else if (!decided && scan_phase == jfml_pkg::PH_TAIL)
                settle(jfml_pkg::ST_NO_END, start_off, 0);
            prev_byte  = '0;
            scan_pos   = '0;
            scan_phase = jfml_pkg::PH_HEAD;
            start_off  = '0;
            tail_org   = '0;
        end else begin
            prev_byte = b.data_byte;
            if (scan_pos != '1)
                scan_pos = scan_pos + 1'b1;
        end
    endfunction

    // Idle cycles before the next beat: none while calm, else mostly short
    function automatic int idle_draw(bit calm);
        if (calm || $urandom_range(0, 2) == 0)
            return 0;
        return int'($urandom_range(0, 15));
    endfunction

    // Filler byte, rich in FF so that stray marker pairs show up
    function automatic logic [7:0] filler();
        if ($urandom_range(0, 7) == 0)
            return jfml_pkg::MARK_LEAD;
        return 8'($urandom_range(0, 255));
    endfunction

    // Queue one frame; origin rides on the first byte, the rest get noise
    task automatic push_frame(input logic [7:0] seq[$], input jfml_pkg::pos_t origin);
        jfml_pkg::in_beat_t beat;
        int                 i;
        for (i = 0; i < seq.size(); i++) begin
            beat.data_byte  = seq[i];
            beat.tail_start = (i == 0) ? origin :
                              jfml_pkg::pos_t'($urandom_range(0, 20'hFFFFF));
            beat.last_byte  = (i == seq.size() - 1);
            byte_stream.push_back(beat);
        end
        phase_bytes += seq.size();
        frames_queued++;
    endtask

    // Build a frame: mostly a planted marker pair with random padding
    task automatic queue_random_frame();
        logic [7:0]     seq[$];
        jfml_pkg::pos_t origin;
        int             lead;
        int             body;
        int             trail;
        int             pick;
        case ($urandom_range(0, 6))
            0: origin = '0;
            1: origin = jfml_pkg::pos_t'($urandom_range(0, 20'hFFFFF));
            default: origin = jfml_pkg::pos_t'($urandom_range(0, 8));
        endcase
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 20)) seq.push_back(filler());
        end else begin
            lead  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 4);
            body  = $urandom_range(0, 12);
            trail = $urandom_range(0, 4);
            pick  = $urandom_range(0, 9);
            repeat (lead) seq.push_back(filler());
            seq.push_back(jfml_pkg::MARK_LEAD);
            seq.push_back(jfml_pkg::MARK_SOI);
            repeat (body) seq.push_back(filler());
            // close with an end marker, a second start marker, or nothing
            if (pick < 6) begin
                seq.push_back(jfml_pkg::MARK_LEAD);
                seq.push_back(jfml_pkg::MARK_EOI);
            end else if (pick < 8) begin
                seq.push_back(jfml_pkg::MARK_LEAD);
                seq.push_back(jfml_pkg::MARK_SOI);
            end
            repeat (trail) seq.push_back(filler());
        end
        push_frame(seq, origin);
    endtask

    // Wait until every byte is in and every report is out, then let the
    // pipeline settle
    task automatic wait_drained();
        do @(negedge aclk);
        while (byte_stream.size() != 0 || s_valid || awaited_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_limit(input jfml_pkg::cfg_index_t idx, input jfml_pkg::pos_t value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_addr <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        if (idx == jfml_pkg::REG_HEAD_LIMIT)
            head_lim = value;
        else
            tail_lim = value;
    endtask

    // Source: one beat per byte, random gaps between beats
    always @(posedge aclk) begin
        jfml_pkg::in_beat_t taken;
        jfml_pkg::in_beat_t nb;
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                taken.data_byte  = s_data_byte;
                taken.tail_start = s_tail_start;
                taken.last_byte  = s_last_byte;
                locate_markers(taken);
                if (decided)
                    awaited_reports.push_back(verdict);
                bytes_sent++;
            end
            if (!s_valid || s_ready) begin
                if ($urandom_range(0, 39) == 0)
                    tx_calm = !tx_calm;
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (byte_stream.size() != 0) begin
                    nb = byte_stream.pop_front();
                    s_valid      <= 1'b1;
                    s_data_byte  <= nb.data_byte;
                    s_tail_start <= nb.tail_start;
                    s_last_byte  <= nb.last_byte;
                    tx_gap = idle_draw(tx_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Sink: check each report beat, then stall at random
    always @(posedge aclk) begin
        jfml_pkg::result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                reports_seen++;
                status_seen[m_status]++;
                if (awaited_reports.size() == 0) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("unexpected report: status %0d head %0d length %0d",
                                 m_status, m_head_offset, m_image_length);
                end else begin
                    want = awaited_reports.pop_front();
                    if (want.status != m_status || want.head_offset != m_head_offset ||
                        want.image_length != m_image_length) begin
                        fault_count++;
                        if (fault_count <= REPORT_LIMIT)
                            $display("report %0d: expected status %0d head %0d length %0d, %s %0d %0d %0d",
                                     reports_seen, want.status, want.head_offset,
                                     want.image_length, "got", m_status,
                                     m_head_offset, m_image_length);
                    end
                end
                if ($urandom_range(0, 19) == 0)
                    rx_calm = !rx_calm;
                rx_wait = idle_draw(rx_calm);
            end
            // take over a long hold when one is requested
            if (rx_hold_len > 0) begin
                rx_wait = rx_hold_len;
                rx_hold_len = 0;
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Abort when no beat moves on either channel for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles", quiet_cycles);
                $display("tb_jpeg_frame_marker_locator: done, errors");
                $finish;
            end
        end
    end

    // Stimulus: directed frames, then random frames under several limit pairs
    initial begin
        jfml_pkg::pos_t head_plan [PHASES];
        jfml_pkg::pos_t tail_plan [PHASES];
        logic [7:0]     seq[$];
        int             p;
        bit             paused;
        head_plan = '{jfml_pkg::HEAD_LIMIT_RESET, 20'd1, 20'hFFFFF, 20'd6, 20'd20, 20'd0,
                      20'd0, jfml_pkg::HEAD_LIMIT_RESET};
        tail_plan = '{jfml_pkg::TAIL_LIMIT_RESET, 20'd1, 20'hFFFFF, 20'd12, 20'd40, 20'd0,
                      20'd0, jfml_pkg::TAIL_LIMIT_RESET};
        head_plan[5] = jfml_pkg::pos_t'($urandom_range(1, 32));
        tail_plan[5] = jfml_pkg::pos_t'($urandom_range(1, 48));
        head_plan[6] = jfml_pkg::pos_t'($urandom_range(1, 32));
        tail_plan[6] = jfml_pkg::pos_t'($urandom_range(1, 48));
        paused = 1'b0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // single byte, frame ends before any marker
        seq = '{8'h00};
        push_frame(seq, '0);
        // shortest complete image
        seq = '{jfml_pkg::MARK_LEAD, jfml_pkg::MARK_SOI, jfml_pkg::MARK_LEAD,
                jfml_pkg::MARK_EOI};
        push_frame(seq, '0);
        // second start marker inside the tail window
        seq = '{jfml_pkg::MARK_LEAD, jfml_pkg::MARK_SOI, jfml_pkg::MARK_LEAD,
                jfml_pkg::MARK_SOI};
        push_frame(seq, '0);
        // frame ends while seeking the end marker
        seq = '{jfml_pkg::MARK_LEAD, jfml_pkg::MARK_SOI, 8'h00};
        push_frame(seq, '0);
        // tail window empty from the start, trailing byte ignored
        seq = '{jfml_pkg::MARK_LEAD, jfml_pkg::MARK_SOI, jfml_pkg::MARK_LEAD};
        push_frame(seq, '1);
        // FF FF D8 still pairs, end found right at the tail start
        seq = '{jfml_pkg::MARK_LEAD, jfml_pkg::MARK_LEAD, jfml_pkg::MARK_SOI,
                jfml_pkg::MARK_LEAD, jfml_pkg::MARK_EOI};
        push_frame(seq, jfml_pkg::pos_t'(2));

        for (p = 0; p < PHASES; p++) begin
            if (p != 0) begin
                wait_drained();
                write_limit(jfml_pkg::REG_HEAD_LIMIT, head_plan[p]);
                write_limit(jfml_pkg::REG_TAIL_LIMIT, tail_plan[p]);
                @(negedge aclk);
            end
            // hold the sink off so the block backs up
            if (p == 3)
                rx_hold_len = LONG_HOLD;
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                queue_random_frame();
                // pause the source until all reports are out
                if (p == 4 && !paused && phase_bytes >= PHASE_BYTES / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("covered %0d bytes in %0d frames over %0d limit pairs; %0d reports, %0d mismatches",
                 bytes_sent, frames_queued, PHASES, reports_seen, fault_count);
        $display("report mix: found %0d, no start %0d, no end %0d, second start %0d",
                 status_seen[jfml_pkg::ST_FOUND], status_seen[jfml_pkg::ST_NO_START],
                 status_seen[jfml_pkg::ST_NO_END], status_seen[jfml_pkg::ST_SECOND_START]);
        if (fault_count == 0)
            $display("tb_jpeg_frame_marker_locator: done, clean");
        else
            $display("tb_jpeg_frame_marker_locator: done, errors");
        $finish;
    end

endmodule
